FILE: src/afbcrc_pkg.sv
// ----------------------------------------------------------------------------
// afbcrc_pkg
// Shared types, constants and the CRC-8 step for the addressed frame builder.
// ----------------------------------------------------------------------------
package afbcrc_pkg;

    // Frame constants
    localparam logic [15:0] MAX_PAYLOAD = 16'd255;
    localparam logic [15:0] INNER_EXTRA = 16'd5;   // timestamp + type
    localparam logic [7:0]  SOF_BYTE0   = 8'hAA;
    localparam logic [7:0]  SOF_BYTE1   = 8'h55;
    localparam logic [7:0]  EOF_BYTE0   = 8'h55;
    localparam logic [7:0]  EOF_BYTE1   = 8'hAA;
    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [7:0]  CRC_INIT    = 8'h00;

    // Stream widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One command per accepted item: which byte groups to send and the data.
    typedef struct packed {
        logic        hdr;          // send 12-byte header
        logic        pay;          // send the payload byte
        logic        trl;          // send CRC and end marker
        logic [7:0]  payload_byte;
        logic [15:0] inner_len;
        logic [31:0] timestamp;
        logic [7:0]  frame_type;
        logic [15:0] dest_addr;
        logic [7:0]  dest_channel;
    } cmd_t;

    // Output byte sequence of one frame
    typedef enum logic [3:0] {
        ST_ADDR_HI,
        ST_ADDR_LO,
        ST_CHAN,
        ST_SOF0,
        ST_SOF1,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_TS3,
        ST_TS2,
        ST_TS1,
        ST_TS0,
        ST_TYPE,
        ST_PAY,
        ST_CRC,
        ST_EOF0,
        ST_EOF1
    } step_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/addressed_frame_builder_crc8.sv
// ----------------------------------------------------------------------------
// addressed_frame_builder_crc8
// Builds addressed, length-prefixed frames with a CRC-8 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one payload byte per item. s_tuser marks the first
//   item of a frame, s_tlast the last; header fields are taken from the first
//   item only. A frame with zero payload is one first item whose byte is
//   ignored. Items outside an open frame are dropped.
//   Output stream (m_*): one frame byte per item, m_tlast on the final AA of
//   the end marker. Frame = addr hi, addr lo, channel, AA 55, inner length
//   (2 bytes, big endian), timestamp (4 bytes, big endian), type, payload,
//   CRC-8, 55 AA.
//   Timing: the front side registers items into a 4-deep command queue; the
//   back side sends one output byte per cycle from it while not stalled. An
//   accepted item is registered into the queue, then its first byte into the
//   output register. Payload items run at one per cycle when not stalled; a
//   first item yields 12 bytes (13 with its payload byte, plus 3 more for a
//   trailer), a last item 4. Input ready drops only when the queue is full.
//   Stall: when m_tready is low the output register holds its byte, the back
//   side waits, and the queue absorbs up to 4 more items.
//   Reset: aresetn (synchronous, active low) empties the queue, closes any
//   open frame and clears the CRC.
// ----------------------------------------------------------------------------
module addressed_frame_builder_crc8 (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // payload_byte[7:0], payload_len[15:8], timestamp[47:16],
    // frame_type[55:48], dest_addr[71:56], dest_channel[79:72]
    input  logic [afbcrc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tlast,   // last_item
    input  logic                              s_tuser,   // first_item
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [afbcrc_pkg::M_TDATA_W-1:0]  m_tdata,   // out_byte[7:0]
    output logic                              m_tlast    // frame_end
);

    logic              q_full;
    logic              q_push;
    afbcrc_pkg::cmd_t  q_push_cmd;
    logic              q_pop;
    logic              q_head_valid;
    afbcrc_pkg::cmd_t  q_head_cmd;

    // Front: accept and classify items
    afbcrc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    // Command queue decouples the two sides
    afbcrc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back: byte sequencer, CRC and output register
    afbcrc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_head_valid),
        .q_cmd    (q_head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: src/afbcrc_front.sv
// ----------------------------------------------------------------------------
// afbcrc_front
// Input side: accepts items, tracks frame state, builds queue commands.
// ----------------------------------------------------------------------------
module afbcrc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [afbcrc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tuser,
    input  logic                              q_full,
    output logic                              q_push,
    output afbcrc_pkg::cmd_t                  q_cmd
);

    logic        in_frame_reg, in_frame_next;
    logic [7:0]  plen;
    logic [15:0] len_sat;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign plen     = s_tdata[15:8];

    always_comb begin
        len_sat = ({8'd0, plen} > afbcrc_pkg::MAX_PAYLOAD) ? afbcrc_pkg::MAX_PAYLOAD
                                                            : {8'd0, plen};

        q_cmd.payload_byte = s_tdata[7:0];
        q_cmd.inner_len    = len_sat + afbcrc_pkg::INNER_EXTRA;
        q_cmd.timestamp    = s_tdata[47:16];
        q_cmd.frame_type   = s_tdata[55:48];
        q_cmd.dest_addr    = s_tdata[71:56];
        q_cmd.dest_channel = s_tdata[79:72];

        // Classify the item
        if (s_tuser) begin
            q_cmd.hdr = 1'b1;
            q_cmd.pay = (plen != 8'd0);
            q_cmd.trl = (plen == 8'd0) || s_tlast;
        end else begin
            q_cmd.hdr = 1'b0;
            q_cmd.pay = 1'b1;
            q_cmd.trl = s_tlast;
        end

        // items outside a frame are dropped
        q_push        = accept && (s_tuser || in_frame_reg);
        in_frame_next = q_push ? !q_cmd.trl : in_frame_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

FILE: src/afbcrc_queue.sv
// ----------------------------------------------------------------------------
// afbcrc_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module afbcrc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  afbcrc_pkg::cmd_t  push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output afbcrc_pkg::cmd_t  head_cmd
);

    afbcrc_pkg::cmd_t                   entry_reg [afbcrc_pkg::QUEUE_DEPTH];
    logic [afbcrc_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [afbcrc_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [afbcrc_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign full       = (count_reg == afbcrc_pkg::QCNT_W'(afbcrc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/afbcrc_back.sv
// ----------------------------------------------------------------------------
// afbcrc_back
// Output side: walks each command's bytes, runs the CRC, drives the output.
// ----------------------------------------------------------------------------
module afbcrc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  afbcrc_pkg::cmd_t                  q_cmd,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [afbcrc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);

    logic                busy_reg, busy_next;
    afbcrc_pkg::step_t   step_reg, step_next;
    logic [7:0]          crc_reg, crc_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    afbcrc_pkg::step_t   cur_step;
    afbcrc_pkg::step_t   after_step;
    logic [7:0]          cur_byte;
    logic [7:0]          crc_base;
    logic                fire;
    logic                done;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        // where the current command starts
        if (busy_reg) begin
            cur_step = step_reg;
        end else if (q_cmd.hdr) begin
            cur_step = afbcrc_pkg::ST_ADDR_HI;
        end else if (q_cmd.pay) begin
            cur_step = afbcrc_pkg::ST_PAY;
        end else begin
            cur_step = afbcrc_pkg::ST_CRC;
        end

        crc_base = (cur_step == afbcrc_pkg::ST_ADDR_HI) ? afbcrc_pkg::CRC_INIT : crc_reg;

        done       = 1'b0;
        after_step = afbcrc_pkg::step_t'(cur_step + 4'd1);
        case (cur_step)
            afbcrc_pkg::ST_ADDR_HI: cur_byte = q_cmd.dest_addr[15:8];
            afbcrc_pkg::ST_ADDR_LO: cur_byte = q_cmd.dest_addr[7:0];
            afbcrc_pkg::ST_CHAN:    cur_byte = q_cmd.dest_channel;
            afbcrc_pkg::ST_SOF0:    cur_byte = afbcrc_pkg::SOF_BYTE0;
            afbcrc_pkg::ST_SOF1:    cur_byte = afbcrc_pkg::SOF_BYTE1;
            afbcrc_pkg::ST_LEN_HI:  cur_byte = q_cmd.inner_len[15:8];
            afbcrc_pkg::ST_LEN_LO:  cur_byte = q_cmd.inner_len[7:0];
            afbcrc_pkg::ST_TS3:     cur_byte = q_cmd.timestamp[31:24];
            afbcrc_pkg::ST_TS2:     cur_byte = q_cmd.timestamp[23:16];
            afbcrc_pkg::ST_TS1:     cur_byte = q_cmd.timestamp[15:8];
            afbcrc_pkg::ST_TS0:     cur_byte = q_cmd.timestamp[7:0];
            afbcrc_pkg::ST_TYPE: begin
                cur_byte   = q_cmd.frame_type;
                after_step = q_cmd.pay ? afbcrc_pkg::ST_PAY : afbcrc_pkg::ST_CRC;
            end
            afbcrc_pkg::ST_PAY: begin
                cur_byte = q_cmd.payload_byte;
                done     = !q_cmd.trl;
            end
            afbcrc_pkg::ST_CRC:     cur_byte = crc_reg;
            afbcrc_pkg::ST_EOF0:    cur_byte = afbcrc_pkg::EOF_BYTE0;
            afbcrc_pkg::ST_EOF1: begin
                cur_byte = afbcrc_pkg::EOF_BYTE1;
                done     = 1'b1;
            end
            default:                cur_byte = 8'h00;
        endcase

        // one byte per cycle whenever a command is queued and the output register is free
        fire  = q_valid && (!m_tvalid_reg || m_tready);
        q_pop = fire && done;

        busy_next     = busy_reg;
        step_next     = step_reg;
        crc_next      = crc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (fire) begin
            busy_next     = !done;
            step_next     = after_step;
            m_tvalid_next = 1'b1;
            m_tdata_next  = cur_byte;
            m_tlast_next  = (cur_step == afbcrc_pkg::ST_EOF1);
            if (cur_step inside {[afbcrc_pkg::ST_TS3:afbcrc_pkg::ST_PAY]}) begin
                crc_next = afbcrc_pkg::crc8_update(crc_base, cur_byte);
            end else if (cur_step == afbcrc_pkg::ST_ADDR_HI) begin
                crc_next = afbcrc_pkg::CRC_INIT;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= afbcrc_pkg::ST_ADDR_HI;
            crc_reg      <= afbcrc_pkg::CRC_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            crc_reg      <= crc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

FILE: tb/afb_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afb_frame_checker
// Watches both streams of the frame builder, predicts the framed byte
// stream from every accepted input item and compares each output item.
// ----------------------------------------------------------------------------
module afb_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          error_count,
    output int          bytes_owed
);

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } frame_byte_t;

    frame_byte_t owed_frame_bytes[$];
    logic [7:0]  crc_run    = afbcrc_pkg::CRC_INIT;
    logic        frame_open = 1'b0;

    // Bit-serial CRC-8, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ afbcrc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic owe_byte(input logic [7:0] data, input logic eof);
        owed_frame_bytes.push_back('{data: data, eof: eof});
    endtask

    task automatic owe_crc_byte(input logic [7:0] data);
        crc_run = crc8_next(crc_run, data);
        owe_byte(data, 1'b0);
    endtask

    task automatic owe_trailer();
        owe_byte(crc_run, 1'b0);
        owe_byte(afbcrc_pkg::EOF_BYTE0, 1'b0);
        owe_byte(afbcrc_pkg::EOF_BYTE1, 1'b1);
        crc_run    = afbcrc_pkg::CRC_INIT;
        frame_open = 1'b0;
    endtask

    task automatic predict_frame_bytes(input logic [79:0] d, input logic is_first,
                                       input logic is_last);
        logic [7:0]  pbyte;
        logic [7:0]  plen;
        logic [31:0] ts;
        logic [15:0] len_sat;
        logic [15:0] inner_len;
        logic        pass_byte;
        pbyte     = d[7:0];
        plen      = d[15:8];
        ts        = d[47:16];
        pass_byte = frame_open;
        if (is_first) begin
            len_sat = {8'h00, plen};
            if (len_sat > afbcrc_pkg::MAX_PAYLOAD) begin
                len_sat = afbcrc_pkg::MAX_PAYLOAD;
            end
            inner_len  = len_sat + afbcrc_pkg::INNER_EXTRA;
            crc_run    = afbcrc_pkg::CRC_INIT;
            frame_open = 1'b1;
            owe_byte(d[71:64], 1'b0);
            owe_byte(d[63:56], 1'b0);
            owe_byte(d[79:72], 1'b0);
            owe_byte(afbcrc_pkg::SOF_BYTE0, 1'b0);
            owe_byte(afbcrc_pkg::SOF_BYTE1, 1'b0);
            owe_byte(inner_len[15:8], 1'b0);
            owe_byte(inner_len[7:0], 1'b0);
            owe_crc_byte(ts[31:24]);
            owe_crc_byte(ts[23:16]);
            owe_crc_byte(ts[15:8]);
            owe_crc_byte(ts[7:0]);
            owe_crc_byte(d[55:48]);
            // empty payload: header plus trailer, byte and last flag ignored
            if (plen == 8'h00) begin
                owe_trailer();
            end
            pass_byte = (plen != 8'h00);
        end
        if (pass_byte) begin
            owe_crc_byte(pbyte);
            if (is_last) begin
                owe_trailer();
            end
        end
    endtask

    task automatic flag_error(input string what, input logic [7:0] exp_data,
                              input logic exp_eof);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s: expected byte %02h tlast %0b, got byte %02h tlast %0b",
                     $realtime, what, exp_data, exp_eof, m_tdata, m_tlast);
        end
    endtask

    always @(posedge aclk) begin
        frame_byte_t exp_byte;
        if (!aresetn) begin
            owed_frame_bytes.delete();
            crc_run    = afbcrc_pkg::CRC_INIT;
            frame_open = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_frame_bytes(s_tdata, s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (owed_frame_bytes.size() == 0) begin
                    flag_error("unexpected output item", 8'h00, 1'b0);
                end else begin
                    exp_byte = owed_frame_bytes.pop_front();
                    if (m_tdata !== exp_byte.data || m_tlast !== exp_byte.eof) begin
                        flag_error("output item mismatch", exp_byte.data, exp_byte.eof);
                    end
                end
            end
        end
        bytes_owed = owed_frame_bytes.size();
    end

endmodule

FILE: tb/tb_addressed_frame_builder_crc8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_addressed_frame_builder_crc8
// Drives payload items into the frame builder and judges the output stream.
// A directed run covers empty frames, field extremes, stray items, abandoned
// frames and early or late last flags; random frames follow under three
// backpressure mixes. The checker predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_addressed_frame_builder_crc8;

    localparam int RANDOM_ITEMS = 360;   // spread over the three idle phases
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 20;    // settle time after the last owed byte

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // payload_byte[7:0], payload_len[15:8], timestamp[47:16],
    // frame_type[55:48], dest_addr[71:56], dest_channel[79:72]
    logic [afbcrc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                             s_tlast  = 1'b0;  // last_item
    logic                             s_tuser  = 1'b0;  // first_item
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [afbcrc_pkg::M_TDATA_W-1:0] m_tdata;          // out_byte[7:0]
    logic                             m_tlast;          // frame_end

    int send_idle_pct = 22;
    int recv_idle_pct = 72;
    int error_count;
    int bytes_owed;

    addressed_frame_builder_crc8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    afb_frame_checker u_frame_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .bytes_owed  (bytes_owed)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver backpressure, redrawn every cycle at the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: ends the run when nothing moves for too long
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // One item on the input side. Called and returning at a falling edge;
    // tvalid stays high when the next item follows without a gap.
    task automatic send_item(input logic [7:0] pbyte, input logic is_first,
                             input logic is_last, input logic [7:0] plen,
                             input logic [31:0] ts, input logic [7:0] ftype,
                             input logic [15:0] addr, input logic [7:0] chan);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {chan, addr, ftype, ts, plen, pbyte};
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_tready;
            @(negedge aclk);
        end
    endtask

    // Non-first item: header fields are don't-care, so fill them with junk
    task automatic send_cont(input logic [7:0] pbyte, input logic is_last);
        send_item(pbyte, 1'b0, is_last, 8'($urandom), $urandom, 8'($urandom),
                  16'($urandom), 8'($urandom));
    endtask

    // Hold the input side until every owed output item has come out
    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (bytes_owed != 0) begin
            @(negedge aclk);
        end
    endtask

    // One random frame. Mostly well formed; some close early or late on the
    // last flag, some are abandoned by the next first item, and a few are
    // followed by stray items that the block must drop.
    task automatic random_frame(output int counted);
        int          plen;
        int          n_items;
        int          mode;
        int          r;
        logic [31:0] ts;
        logic [15:0] addr;
        logic [7:0]  chan;
        logic        is_last;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            plen = 0;
        end else if (r < 80) begin
            plen = $urandom_range(1, 8);
        end else if (r < 96) begin
            plen = $urandom_range(9, 40);
        end else begin
            plen = $urandom_range(41, 255);
        end
        // mode: 0..79 normal, 80..87 early last, 88..93 late last, else abandon
        mode = (plen == 0) ? 0 : $urandom_range(0, 99);
        if (plen == 0 || mode < 80 || mode >= 94) begin
            n_items = (plen == 0) ? 1 : plen;
        end else if (mode < 88) begin
            n_items = $urandom_range(1, plen);
        end else begin
            n_items = plen + $urandom_range(1, 3);
        end
        ts   = $urandom;
        addr = 16'($urandom);
        chan = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            // no destination
            addr = '0;
            chan = '0;
        end
        for (int i = 0; i < n_items; i++) begin
            is_last = (i == n_items - 1) && (mode < 94);
            if (plen == 0) begin
                is_last = 1'($urandom);
            end
            if (i == 0) begin
                send_item(8'($urandom), 1'b1, is_last, 8'(plen), ts, 8'($urandom),
                          addr, chan);
            end else begin
                send_cont(8'($urandom), is_last);
            end
        end
        counted = n_items;
        if (mode < 94 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) send_cont(8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int phase_items;
        int n;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed items ----
        // empty payload, every field at its top value; closes without last
        send_item(8'hFF, 1'b1, 1'b0, 8'h00, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF);
        // empty payload, all zero, last set
        send_item(8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 8'h00, 16'h0000, 8'h00);
        // strays while no frame is open
        send_cont(8'h5A, 1'b0);
        send_cont(8'hA5, 1'b1);
        // one-byte frame, first and last on the same item
        send_item(8'h00, 1'b1, 1'b1, 8'd1, 32'h0000_0001, 8'h80, 16'h8000, 8'h01);
        // length field at its top value, frame closed after three bytes
        send_item(8'h80, 1'b1, 1'b0, 8'd255, 32'h8000_0000, 8'h7F, 16'h0001, 8'h80);
        send_cont(8'h7F, 1'b0);
        send_cont(8'hFF, 1'b1);
        // open frame abandoned by a new first item
        send_item(8'h11, 1'b1, 1'b0, 8'd4, 32'h1234_5678, 8'h42, 16'h00FF, 8'h17);
        send_cont(8'h22, 1'b0);
        send_item(8'h33, 1'b1, 1'b0, 8'd2, 32'hDEAD_BEEF, 8'h03, 16'hFF00, 8'h2C);
        send_cont(8'h44, 1'b1);
        // last flag well before the declared length
        send_item(8'hC3, 1'b1, 1'b0, 8'd200, 32'h0F0F_F0F0, 8'h01, 16'h5555, 8'hAA);
        send_cont(8'h3C, 1'b1);
        // last flag after the declared length
        send_item(8'h01, 1'b1, 1'b0, 8'd2, 32'h7FFF_FFFF, 8'hFE, 16'hAAAA, 8'h55);
        send_cont(8'h02, 1'b0);
        send_cont(8'h04, 1'b0);
        send_cont(8'h08, 1'b0);
        send_cont(8'h10, 1'b1);
        // open frame replaced by an empty one
        send_item(8'h96, 1'b1, 1'b0, 8'd3, 32'hCAFE_F00D, 8'h10, 16'h1234, 8'h09);
        send_item(8'h69, 1'b1, 1'b0, 8'd0, 32'h0000_FFFF, 8'hEF, 16'hFFFE, 8'h7F);
        // stray right after a close
        send_cont(8'hE7, 1'b0);
        drain_output();

        // ---- random frames in three backpressure phases ----
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 3) begin
                random_frame(n);
                phase_items += n;
            end
            // sender pause: wait out every owed byte before the next phase
            drain_output();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && bytes_owed == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
